// ===== src/escaped_api_frame_deframer_top_macros.svh =====
// ----------------------------------------------------------------------------
// escaped_api_frame_deframer_top_macros.svh
// Assertion macros used by the deframer parser module (eafd_back).
// ----------------------------------------------------------------------------
`ifndef ESCAPED_API_FRAME_DEFRAMER_TOP_MACROS_SVH
`define ESCAPED_API_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define EAFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EAFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eafd_pkg.sv =====
// ----------------------------------------------------------------------------
// eafd_pkg
// Types and constants of the escaped frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eafd_pkg;

    localparam logic [7:0]  START_BYTE        = 8'h7E;
    localparam logic [7:0]  ESCAPE_BYTE       = 8'h7D;
    localparam logic [7:0]  ESCAPE_XOR        = 8'h20;
    localparam logic [7:0]  SUM_TARGET        = 8'hFF;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd128;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    typedef struct packed {
        logic       is_start;
        logic [7:0] data;
    } tok_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last_payload;
        logic [15:0] frame_length;
    } res_t;

endpackage

// ===== src/eafd_fifo.sv =====
// ----------------------------------------------------------------------------
// eafd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eafd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/eafd_front.sv =====
// ----------------------------------------------------------------------------
// eafd_front
// Accept raw bytes, strip escapes and classify into start or data tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eafd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        rx_byte,
    output logic              full,
    input  logic              tok_full,
    output logic              tok_push,
    output eafd_pkg::tok_t    tok_data
);

    logic escape_reg, escape_next;
    logic accept;
    logic is_start;
    logic is_escape;

    assign full      = tok_full;
    assign accept    = push && !tok_full;
    assign is_start  = (rx_byte == eafd_pkg::START_BYTE);
    assign is_escape = (rx_byte == eafd_pkg::ESCAPE_BYTE);
    assign tok_push  = accept && !is_escape;

    always_comb
    begin
        tok_data.is_start = is_start;
        tok_data.data     = escape_reg ? (rx_byte ^ eafd_pkg::ESCAPE_XOR) : rx_byte;
        escape_next       = escape_reg;
        if (accept)
        begin
            escape_next = is_escape;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
        end
    end

endmodule

// ===== src/eafd_back.sv =====
// ----------------------------------------------------------------------------
// eafd_back
// Parse tokens into header, payload and checksum; produce result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "escaped_api_frame_deframer_top_macros.svh"

module eafd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       max_payload,
    input  logic              tok_empty,
    input  eafd_pkg::tok_t    tok_data,
    output logic              tok_pop,
    input  logic              res_full,
    output logic              res_push,
    output eafd_pkg::res_t    res_data
);

    localparam logic [2:0] ST_HUNT   = 3'd0;
    localparam logic [2:0] ST_LEN_HI = 3'd1;
    localparam logic [2:0] ST_LEN_LO = 3'd2;
    localparam logic [2:0] ST_DATA   = 3'd3;
    localparam logic [2:0] ST_CKSUM  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  sum_reg, sum_next;
    logic        has_result;
    logic [15:0] len_full;
    logic [7:0]  sum_add;

    assign tok_pop  = !tok_empty && !res_full;
    assign res_push = tok_pop && has_result;
    assign len_full = {len_reg[15:8], tok_data.data};
    assign sum_add  = sum_reg + tok_data.data;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        has_result = 1'b0;
        res_data   = '0;
        res_data.frame_length = len_reg;
        if (tok_data.is_start)
        begin
            state_next = ST_LEN_HI;
        end
        else
        begin
            case (state_reg)
                ST_LEN_HI:
                begin
                    len_next   = {tok_data.data, 8'h00};
                    state_next = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    len_next = len_full;
                    if (len_full > max_payload)
                    begin
                        state_next            = ST_HUNT;
                        has_result            = 1'b1;
                        res_data.kind         = eafd_pkg::KIND_TOO_LONG;
                        res_data.frame_length = len_full;
                    end
                    else
                    begin
                        sum_next   = '0;
                        rem_next   = len_full;
                        state_next = (len_full != '0) ? ST_DATA : ST_CKSUM;
                    end
                end
                ST_DATA:
                begin
                    has_result            = 1'b1;
                    res_data.kind         = eafd_pkg::KIND_PAYLOAD;
                    res_data.payload_byte = tok_data.data;
                    res_data.byte_index   = len_reg - rem_reg;
                    res_data.last_payload = (rem_reg <= 16'd1);
                    sum_next              = sum_add;
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                    if (rem_reg <= 16'd1)
                    begin
                        state_next = ST_CKSUM;
                    end
                end
                ST_CKSUM:
                begin
                    sum_next      = sum_add;
                    state_next    = ST_HUNT;
                    has_result    = 1'b1;
                    res_data.kind = (sum_add == eafd_pkg::SUM_TARGET) ?
                                    eafd_pkg::KIND_GOOD : eafd_pkg::KIND_BAD_SUM;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            len_reg   <= '0;
            rem_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (tok_pop)
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            sum_reg   <= sum_next;
        end
    end

    `EAFD_ASSERT_IMP(a_data_has_bytes, clk, rst_n, state_reg == ST_DATA, rem_reg != '0,
        "payload state with no bytes remaining")
    `EAFD_ASSERT_IMP(a_push_has_room, clk, rst_n, res_push, !res_full,
        "result pushed into a full queue")
    `EAFD_ASSERT_NXT(a_last_to_cksum, clk, rst_n,
        tok_pop && !tok_data.is_start && state_reg == ST_DATA && rem_reg == 16'd1,
        state_reg == ST_CKSUM, "last payload byte did not lead to checksum")
    `EAFD_ASSERT_NXT(a_start_to_hdr, clk, rst_n, tok_pop && tok_data.is_start,
        state_reg == ST_LEN_HI, "start token did not restart header parsing")

endmodule

// ===== src/escaped_api_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// escaped_api_frame_deframer_top
// Deframer for 0x7E-delimited, 0x7D-escaped frames with an additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while full is low and returns at most one
// result per byte, so a steady stream of one byte per cycle passes without
// stalling while the result side keeps popping. The front stage strips
// escapes into a token queue, and the parser pops a token and pushes its
// result into the result queue at the same edge; the result can then be
// popped from the result queue. Both queues are TOK_DEPTH and RES_DEPTH
// entries deep; full rises only when the result side stops popping and both
// queues have filled. Payload bytes are delivered as they arrive, so the
// consumer must discard a frame whose closing status is not "frame good".
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_api_frame_deframer_top #(
    parameter int TOK_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        push,
    input  logic [7:0]  rx_byte,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_index,
    output logic        last_payload,
    output logic [15:0] frame_length
);

    logic [15:0]    max_payload_reg;
    logic           tok_push;
    logic           tok_full;
    logic           tok_empty;
    logic           tok_pop;
    eafd_pkg::tok_t tok_wr;
    eafd_pkg::tok_t tok_rd;
    logic           res_push;
    logic           res_full;
    eafd_pkg::res_t res_wr;
    eafd_pkg::res_t res_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= eafd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    eafd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .tok_full (tok_full),
        .tok_push (tok_push),
        .tok_data (tok_wr)
    );

    eafd_fifo #(
        .WIDTH ($bits(eafd_pkg::tok_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (tok_push),
        .wr_data (tok_wr),
        .full    (tok_full),
        .pop     (tok_pop),
        .rd_data (tok_rd),
        .empty   (tok_empty)
    );

    eafd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_payload (max_payload_reg),
        .tok_empty   (tok_empty),
        .tok_data    (tok_rd),
        .tok_pop     (tok_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_wr)
    );

    eafd_fifo #(
        .WIDTH ($bits(eafd_pkg::res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign kind         = res_rd.kind;
    assign payload_byte = res_rd.payload_byte;
    assign byte_index   = res_rd.byte_index;
    assign last_payload = res_rd.last_payload;
    assign frame_length = res_rd.frame_length;

endmodule
